@@ sv/kcl_pkg.sv @@
// Package for the keypad code lock: field widths, key and status codes,
// the result word type and the code that the store holds after reset.
// No dependencies.
`default_nettype none

package kcl_pkg;

    localparam int KEY_W    = 4;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 4;

    localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;
    localparam logic [KEY_W-1:0] KEY_NONE = 4'd0;

    localparam logic CMD_KEY = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic [KEY_W-1:0] RESET_KEY_FIRST  = 4'd7;
    localparam logic [KEY_W-1:0] RESET_KEY_SECOND = 4'd8;
    localparam logic [KEY_W-1:0] RESET_KEY_THIRD  = 4'd9;
    localparam int               RESET_LENGTH     = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_SET_STARTED = 3'd0,
        ST_KEY_TAKEN   = 3'd1,
        ST_CODE_STORED = 3'd2,
        ST_CORRECT     = 3'd3,
        ST_WRONG       = 3'd4
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [KEY_W-1:0]  echo_key;
    } result_t;

    function automatic logic [KEY_W-1:0] reset_key(input int idx);
        logic [KEY_W-1:0] key;
        case (idx)
            0:       key = RESET_KEY_FIRST;
            1:       key = RESET_KEY_SECOND;
            2:       key = RESET_KEY_THIRD;
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

@@ sv/keypad_code_lock_top.sv @@
// Keypad code lock top level: one result word per accepted key word.
// m_valid rises the cycle after acceptance; one word is taken per cycle while
// m_ready is high, set by the single result register, refilled as it drains.
// Reset (aresetn low, synchronous) empties the result register, selects check
// mode, clears the entry and restores the stored code 7 8 9.
// Depends on kcl_pkg, kcl_code_store and kcl_ctrl.
`default_nettype none

module keypad_code_lock_top #(
    parameter int MAX_KEYS = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_command,
    input  wire logic [kcl_pkg::KEY_W-1:0]          s_key_code,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [kcl_pkg::STATUS_W-1:0]       m_status,
    output logic      [kcl_pkg::KEY_W-1:0]          m_echo_key
);

    localparam int IDX_W = $clog2(MAX_KEYS);

    logic                      accept;
    logic [IDX_W-1:0]          rd_idx;
    logic [kcl_pkg::KEY_W-1:0] rd_data;
    logic                      wr_en;
    kcl_pkg::result_t          result;
    kcl_pkg::result_t          result_reg;
    logic                      valid_reg;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    kcl_code_store #(
        .DEPTH (MAX_KEYS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_idx  (rd_idx),
        .wr_data (s_key_code),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    kcl_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .command  (s_command),
        .key_code (s_key_code),
        .rd_data  (rd_data),
        .rd_idx   (rd_idx),
        .wr_en    (wr_en),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_valid    = valid_reg;
    assign m_status   = result_reg.status;
    assign m_echo_key = result_reg.echo_key;

`ifndef ASSERT_OFF
    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted key word produced no result word");

    a_set_echo_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == kcl_pkg::ST_SET_STARTED) |-> m_echo_key == kcl_pkg::KEY_NONE)
        else $error("set command result carries a nonzero echo");

    a_hash_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == kcl_pkg::ST_CODE_STORED) || (m_status == kcl_pkg::ST_CORRECT)
                    || (m_status == kcl_pkg::ST_WRONG))
        |-> m_echo_key == kcl_pkg::KEY_HASH)
        else $error("terminator result does not echo the hash key");
`endif

endmodule

`default_nettype wire

@@ sv/kcl_code_store.sv @@
// Register file that holds the stored code, one key per entry, with one
// write port and one read port. Uses kcl_pkg for the key width and reset code.
`default_nettype none

module kcl_code_store #(
    parameter int DEPTH = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]       wr_idx,
    input  wire logic [kcl_pkg::KEY_W-1:0]      wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]       rd_idx,
    output logic      [kcl_pkg::KEY_W-1:0]      rd_data
);

    logic [kcl_pkg::KEY_W-1:0] code_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                code_reg[i] <= kcl_pkg::reset_key(i);
            end
        end else if (wr_en && (32'(wr_idx) < DEPTH)) begin
            code_reg[wr_idx] <= wr_data;
        end
    end

    always_comb begin
        if (32'(rd_idx) < DEPTH) begin
            rd_data = code_reg[rd_idx];
        end else begin
            rd_data = kcl_pkg::KEY_NONE;
        end
    end

endmodule

`default_nettype wire

@@ sv/kcl_ctrl.sv @@
// Entry control for the keypad code lock: mode, entry count, flags and the
// stored length, plus the result of the current word. Uses kcl_pkg.
`default_nettype none

module kcl_ctrl #(
    parameter int MAX_KEYS = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           accept,
    input  wire logic                           command,
    input  wire logic [kcl_pkg::KEY_W-1:0]      key_code,
    input  wire logic [kcl_pkg::KEY_W-1:0]      rd_data,
    output logic      [$clog2(MAX_KEYS)-1:0]    rd_idx,
    output logic                                wr_en,
    output kcl_pkg::result_t                    result
);

    localparam int IDX_W = $clog2(MAX_KEYS);
    localparam logic [kcl_pkg::CNT_W-1:0] MAX_CNT = kcl_pkg::CNT_W'(MAX_KEYS);
    localparam logic [kcl_pkg::CNT_W-1:0] RESET_LEN =
        kcl_pkg::CNT_W'((MAX_KEYS >= kcl_pkg::RESET_LENGTH) ? kcl_pkg::RESET_LENGTH
                                                          : MAX_KEYS);

    logic [kcl_pkg::CNT_W-1:0] count_reg, count_next;
    logic [kcl_pkg::CNT_W-1:0] length_reg, length_next;
    logic                      mismatch_reg, mismatch_next;
    logic                      overflow_reg, overflow_next;
    logic                      setting_reg, setting_next;

    assign rd_idx = count_reg[IDX_W-1:0];

    always_comb begin
        count_next    = count_reg;
        length_next   = length_reg;
        mismatch_next = mismatch_reg;
        overflow_next = overflow_reg;
        setting_next  = setting_reg;
        wr_en         = 1'b0;
        result.status   = kcl_pkg::ST_KEY_TAKEN;
        result.echo_key = key_code;

        if (command == kcl_pkg::CMD_SET) begin
            count_next      = '0;
            mismatch_next   = 1'b0;
            overflow_next   = 1'b0;
            setting_next    = 1'b1;
            result.status   = kcl_pkg::ST_SET_STARTED;
            result.echo_key = kcl_pkg::KEY_NONE;
        end else if (key_code == kcl_pkg::KEY_HASH) begin
            if (setting_reg) begin
                length_next   = count_reg;
                result.status = kcl_pkg::ST_CODE_STORED;
            end else if (!mismatch_reg && !overflow_reg && (count_reg == length_reg)) begin
                result.status = kcl_pkg::ST_CORRECT;
            end else begin
                result.status = kcl_pkg::ST_WRONG;
            end
            count_next      = '0;
            mismatch_next   = 1'b0;
            overflow_next   = 1'b0;
            setting_next    = 1'b0;
            result.echo_key = kcl_pkg::KEY_HASH;
        end else if (count_reg < MAX_CNT) begin
            if (setting_reg) begin
                wr_en = accept;
            end else if ((count_reg >= length_reg) || (rd_data != key_code)) begin
                mismatch_next = 1'b1;
            end
            count_next = count_reg + 1'b1;
        end else begin
            overflow_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            length_reg   <= RESET_LEN;
            mismatch_reg <= 1'b0;
            overflow_reg <= 1'b0;
            setting_reg  <= 1'b0;
        end else if (accept) begin
            count_reg    <= count_next;
            length_reg   <= length_next;
            mismatch_reg <= mismatch_next;
            overflow_reg <= overflow_next;
            setting_reg  <= setting_next;
        end
    end

endmodule

`default_nettype wire
